// ----- hw/rtl/prhfg_pkg.sv -----
// Shared types and constants for the pulse-rate high-flow guard.
// No dependencies; every other file but prhfg_div imports this package.
package prhfg_pkg;

  // Field widths
  localparam int STAMP_W   = 32;
  localparam int FLOW_W    = 23;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;

  // Default and largest estimation window, in stamps
  localparam int WINDOW_DEF = 20;
  localparam int WINDOW_MAX = 20;

  // Arithmetic constants
  localparam int SECS_PER_HOUR = 3600;
  localparam int SCALE_NUM     = 100;
  localparam logic [STAMP_W-1:0] IDLE_MARK = '1;

  // Input command codes
  localparam logic CMD_PULSE = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GUARD_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_METER_SCALE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_FLOW     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_IDLE_PUSH    = 2'd3;

  // Register reset values
  localparam logic [CFG_W-1:0] METER_SCALE_RST = 16'd100;
  localparam logic [CFG_W-1:0] MAX_FLOW_RST    = 16'd480;
  localparam logic [CFG_W-1:0] IDLE_PUSH_RST   = 16'd60;

  // Controller to datapath commands
  typedef struct packed {
    logic load;        // capture the accepted item, clear result fields
    logic update;      // apply push, idle counter and pending updates
    logic check;       // evaluate the check; clear flag when guard disabled
    logic div1_start;  // start rate = window*3600 / span
    logic mul;         // scale the first quotient by 100
    logic div2_start;  // start flow = scaled / meter_scale
    logic finish;      // compare against max_flow, set flag and shutoff
    logic out_load;    // move result fields into the output register
  } prhfg_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic div_needed;
    logic div_busy;
    logic div_done;
  } prhfg_sts_t;

endpackage

// ----- hw/rtl/prhfg_div.sv -----
// Radix-2 restoring divider: one quotient bit per cycle.
// Depends on nothing; used by prhfg_datapath for both divisions.
module prhfg_div #(
  parameter int NUM_W = 23,
  parameter int DEN_W = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             busy,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  localparam int CNT_W = (NUM_W > 1) ? $clog2(NUM_W) : 1;

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [NUM_W-1:0] quo_r, quo_nxt;
  logic [DEN_W:0]   shifted;
  logic [DEN_W:0]   diff;

  // Trial subtract of one step
  assign shifted = {rem_r, quo_r[NUM_W-1]};
  assign diff    = shifted - {1'b0, den_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      den_nxt  = den;
      quo_nxt  = num;
    end else if (busy_r) begin
      if (!diff[DEN_W]) begin
        rem_nxt = diff[DEN_W-1:0];
      end else begin
        rem_nxt = shifted[DEN_W-1:0];
      end
      quo_nxt = {quo_r[NUM_W-2:0], ~diff[DEN_W]};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(NUM_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    quo_r <= quo_nxt;
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quo  = quo_r;

  // Done pulses only at the end of a running division
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r))
    else $error("divider done without a running division");

endmodule

// ----- hw/rtl/prhfg_datapath.sv -----
// Datapath: config registers, stamp history, idle counter, flag and the
// divide/scale chain for the flow estimate. Uses prhfg_pkg and prhfg_div.
module prhfg_datapath #(
  parameter int WINDOW = prhfg_pkg::WINDOW_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [prhfg_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [prhfg_pkg::CFG_W-1:0]         cfg_data,
  input  logic                                in_command,
  input  logic [prhfg_pkg::STAMP_W-1:0]       in_pulse_time,
  input  logic                                in_valve_open,
  input  prhfg_pkg::prhfg_cmd_t               cmd,
  output prhfg_pkg::prhfg_sts_t               sts,
  output logic [prhfg_pkg::FLOW_W-1:0]        out_flow_estimate,
  output logic                                out_decided,
  output logic                                out_high_flow,
  output logic                                out_shutoff_request
);
  import prhfg_pkg::*;

  localparam int RUN_W  = $clog2(WINDOW + 1);
  localparam int NUM1   = WINDOW * SECS_PER_HOUR;
  localparam int Q1_W   = $clog2(NUM1 + 1);

  // Configuration registers
  logic             guard_enable_r;
  logic [CFG_W-1:0] meter_scale_r;
  logic [CFG_W-1:0] max_flow_r;
  logic [CFG_W-1:0] idle_push_r;

  // Item and block state
  logic               command_r;
  logic [STAMP_W-1:0] pulse_time_r;
  logic               valve_r;
  logic [STAMP_W-1:0] hist_r [WINDOW+1];
  logic [CFG_W-1:0]   ssp_r, ssp_nxt;
  logic [RUN_W-1:0]   run_r, run_nxt;
  logic               pending_r, pending_nxt;
  logic               check_req_r, check_req_nxt;
  logic               flag_r, flag_nxt;
  logic [FLOW_W-1:0]  scaled_r;

  // Result fields
  logic [FLOW_W-1:0] res_flow_r;
  logic              res_decided_r;
  logic              res_shut_r;

  // Update-step signals
  logic [CFG_W-1:0]   ssp_inc;
  logic               push_now;
  logic               push_eff;
  logic [STAMP_W-1:0] push_val;
  logic               pending_eff;

  // Check-step signals
  logic [STAMP_W:0]   span_diff;
  logic [STAMP_W-1:0] span;
  logic               window_full;

  // Divider
  logic              div_start;
  logic [FLOW_W-1:0] div_num;
  logic [STAMP_W-1:0] div_den;
  logic              div_busy;
  logic              div_done;
  logic [FLOW_W-1:0] div_quo;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      guard_enable_r <= 1'b0;
      meter_scale_r  <= METER_SCALE_RST;
      max_flow_r     <= MAX_FLOW_RST;
      idle_push_r    <= IDLE_PUSH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GUARD_ENABLE: guard_enable_r <= cfg_data[0];
        REG_METER_SCALE:  meter_scale_r  <= cfg_data;
        REG_MAX_FLOW:     max_flow_r     <= cfg_data;
        REG_IDLE_PUSH:    idle_push_r    <= cfg_data;
      endcase
    end
  end

  // Capture the accepted item
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      command_r    <= in_command;
      pulse_time_r <= in_pulse_time;
      valve_r      <= in_valve_open;
    end
  end

  // Decide what this item pushes
  assign ssp_inc     = (ssp_r != '1) ? ssp_r + 1'b1 : ssp_r;
  assign push_now    = (command_r == CMD_PULSE) || (ssp_inc >= idle_push_r);
  assign push_eff    = push_now && valve_r;
  assign push_val    = (command_r == CMD_PULSE) ? pulse_time_r : IDLE_MARK;
  assign pending_eff = pending_r || push_eff;

  always_comb begin
    ssp_nxt       = ssp_r;
    run_nxt       = run_r;
    pending_nxt   = pending_r;
    check_req_nxt = check_req_r;
    if (cmd.update) begin
      ssp_nxt = push_now ? '0 : ssp_inc;
      if (push_eff) begin
        if (push_val == IDLE_MARK) begin
          run_nxt = '0;
        end else if (run_r != RUN_W'(WINDOW)) begin
          run_nxt = run_r + 1'b1;
        end
      end
      check_req_nxt = (command_r == CMD_TICK) && pending_eff;
      pending_nxt   = pending_eff && (command_r != CMD_TICK);
    end
  end

  // Shift the stamp history, newest first
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= WINDOW; k++) begin
        hist_r[k] <= IDLE_MARK;
      end
    end else if (cmd.update && push_eff) begin
      hist_r[0] <= push_val;
      for (int k = 1; k <= WINDOW; k++) begin
        hist_r[k] <= hist_r[k-1];
      end
    end
  end

  // Span between newest stamp and the one a window older
  assign span_diff   = {1'b0, hist_r[0]} - {1'b0, hist_r[WINDOW]};
  assign span        = (span_diff[STAMP_W-1:0] == '0) ? STAMP_W'(1) : span_diff[STAMP_W-1:0];
  assign window_full = (run_r == RUN_W'(WINDOW));

  assign sts.div_needed = check_req_r && valve_r && guard_enable_r && window_full
                          && !span_diff[STAMP_W];
  assign sts.div_busy   = div_busy;
  assign sts.div_done   = div_done;

  // Feed the shared divider
  assign div_start = cmd.div1_start || cmd.div2_start;
  assign div_num   = cmd.div1_start ? FLOW_W'(NUM1) : scaled_r;
  assign div_den   = cmd.div1_start ? span
                   : ((meter_scale_r == '0) ? STAMP_W'(1) : STAMP_W'(meter_scale_r));

  prhfg_div #(
    .NUM_W (FLOW_W),
    .DEN_W (STAMP_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .done  (div_done),
    .quo   (div_quo)
  );

  // Scale the rate by 100
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      scaled_r <= FLOW_W'(div_quo[Q1_W-1:0] * 7'(SCALE_NUM));
    end
  end

  // Flag: clear when disabled, set or clear on a full comparison
  always_comb begin
    flag_nxt = flag_r;
    if (cmd.check && check_req_r && valve_r && !guard_enable_r) begin
      flag_nxt = 1'b0;
    end else if (cmd.finish) begin
      flag_nxt = (div_quo >= FLOW_W'(max_flow_r));
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ssp_r       <= '0;
      run_r       <= '0;
      pending_r   <= 1'b0;
      check_req_r <= 1'b0;
      flag_r      <= 1'b0;
    end else begin
      ssp_r       <= ssp_nxt;
      run_r       <= run_nxt;
      pending_r   <= pending_nxt;
      check_req_r <= check_req_nxt;
      flag_r      <= flag_nxt;
    end
  end

  // Result fields: cleared per item, filled on a full comparison
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_flow_r    <= '0;
      res_decided_r <= 1'b0;
      res_shut_r    <= 1'b0;
    end else if (cmd.load) begin
      res_flow_r    <= '0;
      res_decided_r <= 1'b0;
      res_shut_r    <= 1'b0;
    end else if (cmd.finish) begin
      res_flow_r    <= div_quo;
      res_decided_r <= 1'b1;
      res_shut_r    <= (div_quo >= FLOW_W'(max_flow_r));
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_flow_estimate   <= res_flow_r;
      out_decided         <= res_decided_r;
      out_high_flow       <= flag_r;
      out_shutoff_request <= res_shut_r;
    end
  end

  // Run of real stamps never exceeds the window
  a_run_bound: assert property (@(posedge clk) disable iff (!rst_n)
    run_r <= RUN_W'(WINDOW))
    else $error("stamp run count beyond window");

  // A shutoff request always comes with the flag raised
  a_shut_flag: assert property (@(posedge clk) disable iff (!rst_n)
    res_shut_r |-> flag_r)
    else $error("shutoff request without high flow flag");

  // A full comparison only happens with the valve open
  a_decided_valve: assert property (@(posedge clk) disable iff (!rst_n)
    res_decided_r |-> valve_r)
    else $error("flow decided with valve closed");

endmodule

// ----- hw/rtl/prhfg_ctrl.sv -----
// Controller state machine: sequences update, check, two divisions and
// the output handoff. Uses prhfg_pkg for command and status structs.
module prhfg_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  logic                   out_ready,
  output prhfg_pkg::prhfg_cmd_t  cmd,
  input  prhfg_pkg::prhfg_sts_t  sts
);
  import prhfg_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_UPDATE = 3'd1;
  localparam logic [2:0] S_CHECK  = 3'd2;
  localparam logic [2:0] S_DIV1   = 3'd3;
  localparam logic [2:0] S_MUL    = 3'd4;
  localparam logic [2:0] S_DIV2   = 3'd5;
  localparam logic [2:0] S_FINAL  = 3'd6;
  localparam logic [2:0] S_OUT    = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE);

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_UPDATE;
        end
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt  = S_CHECK;
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        if (sts.div_needed) begin
          cmd.div1_start = 1'b1;
          state_nxt      = S_DIV1;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_DIV1: begin
        if (sts.div_done) begin
          cmd.mul   = 1'b1;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.div2_start = 1'b1;
        state_nxt      = S_DIV2;
      end
      S_DIV2: begin
        if (sts.div_done) begin
          state_nxt = S_FINAL;
        end
      end
      S_FINAL: begin
        cmd.finish = 1'b1;
        state_nxt  = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
    endcase
  end

  // Hold the result until taken
  assign out_valid_nxt = cmd.out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  // While waiting on a division the divider is running or just finished
  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV1 || state_r == S_DIV2) |-> (sts.div_busy || sts.div_done))
    else $error("waiting on divider that is not running");

  // A new result appears only from the output state
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_OUT)
    else $error("result valid raised outside output state");

  // The divider is never started while it is busy
  a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.div1_start || cmd.div2_start) |-> !sts.div_busy)
    else $error("divider restarted while busy");

endmodule

// ----- hw/rtl/pulse_rate_high_flow_guard.sv -----
// Top level of the meter pulse-rate high-flow guard.
// Depends on prhfg_pkg, prhfg_ctrl, prhfg_datapath (and prhfg_div below it).
//
// Channel   Handshake              Payload
// in        in_valid / in_ready    in_command, in_pulse_time, in_valve_open
// out       out_valid / out_ready  out_flow_estimate, out_decided,
//                                  out_high_flow, out_shutoff_request
// cfg       cfg_we                 cfg_index, cfg_data
//
// An item without a flow check passes through the update, check and output
// states from accept to result; one with a check also runs two divisions in
// a row on the shared serial divider (one quotient bit a cycle).
// Reset is synchronous and active low; it loads all-ones markers into the
// history and the register defaults. A waiting result sits in the output
// register; the next item is accepted meanwhile and waits only at handoff.
module pulse_rate_high_flow_guard #(
  parameter int WINDOW = prhfg_pkg::WINDOW_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [prhfg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [prhfg_pkg::CFG_W-1:0]     cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_command,
  input  logic [prhfg_pkg::STAMP_W-1:0]   in_pulse_time,
  input  logic                            in_valve_open,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [prhfg_pkg::FLOW_W-1:0]    out_flow_estimate,
  output logic                            out_decided,
  output logic                            out_high_flow,
  output logic                            out_shutoff_request
);
  import prhfg_pkg::*;

  prhfg_cmd_t cmd;
  prhfg_sts_t sts;

  // Sequence each item
  prhfg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // State, arithmetic and output register
  prhfg_datapath #(
    .WINDOW (WINDOW)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_command          (in_command),
    .in_pulse_time       (in_pulse_time),
    .in_valve_open       (in_valve_open),
    .cmd                 (cmd),
    .sts                 (sts),
    .out_flow_estimate   (out_flow_estimate),
    .out_decided         (out_decided),
    .out_high_flow       (out_high_flow),
    .out_shutoff_request (out_shutoff_request)
  );

endmodule

// ----- tb/tb.sv -----
// Testbench for pulse_rate_high_flow_guard: random pulse trains, ticks and noise
// checked against an in-bench predictor of the flow guard.
// Depends on prhfg_pkg and the pulse_rate_high_flow_guard RTL.
`timescale 1ns / 100ps

module tb;
  import prhfg_pkg::*;

  localparam int HISTORY_LEN = 32;
  localparam int WIN = (WINDOW_DEF > WINDOW_MAX) ? WINDOW_MAX : WINDOW_DEF;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic [FLOW_W-1:0] flow;
    logic              decided;
    logic              high;
    logic              shut;
  } guard_report_t;

  // Predict the guard's report for every accepted item and check what comes out
  class flow_guard_tracker;
    logic [STAMP_W-1:0] stamps [HISTORY_LEN];
    logic [15:0]        idle_secs;
    bit                 pending;
    bit                 flag;
    bit                 enable;
    logic [CFG_W-1:0]   scale;
    logic [CFG_W-1:0]   flow_limit;
    logic [CFG_W-1:0]   idle_limit;
    guard_report_t      expected_reports [$];
    int                 mismatches;

    function new();
      foreach (stamps[k]) stamps[k] = IDLE_MARK;
      idle_secs  = '0;
      pending    = 0;
      flag       = 0;
      enable     = 0;
      scale      = METER_SCALE_RST;
      flow_limit = MAX_FLOW_RST;
      idle_limit = IDLE_PUSH_RST;
      mismatches = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        REG_GUARD_ENABLE: enable = data[0];
        REG_METER_SCALE:  scale = data;
        REG_MAX_FLOW:     flow_limit = data;
        REG_IDLE_PUSH:    idle_limit = data;
        default: ;
      endcase
    endfunction

    // Shift a stamp in while the valve is open; always restart the idle count
    function void push_stamp(logic [STAMP_W-1:0] stamp, bit valve);
      idle_secs = '0;
      if (!valve) return;
      for (int k = HISTORY_LEN - 1; k > 0; k--) stamps[k] = stamps[k-1];
      stamps[0] = stamp;
      pending = 1;
    endfunction

    // Estimate flow over the window; return 1 when a comparison was made
    function bit estimate_flow(bit valve, output logic [FLOW_W-1:0] flow, output bit shut);
      int unsigned span;
      int unsigned rate;
      int unsigned div;
      flow = '0;
      shut = 0;
      if (!valve) return 0;
      if (!enable) begin
        flag = 0;
        return 0;
      end
      for (int k = 0; k < WIN; k++) begin
        if (stamps[k] == IDLE_MARK) return 0;
      end
      if (stamps[0] < stamps[WIN]) return 0;
      span = stamps[0] - stamps[WIN];
      if (span == 0) span = 1;
      rate = (WIN * SECS_PER_HOUR) / span;
      div  = (scale == 0) ? 1 : scale;
      rate = (rate * SCALE_NUM) / div;
      flow = rate[FLOW_W-1:0];
      shut = (rate >= flow_limit);
      flag = shut;
      return 1;
    endfunction

    function void accept_item(logic cmd, logic [STAMP_W-1:0] stamp, logic valve);
      guard_report_t rep;
      logic [FLOW_W-1:0] flow;
      bit shut;
      rep = '0;
      if (cmd == CMD_PULSE) begin
        push_stamp(stamp, valve);
      end else begin
        if (idle_secs != 16'hFFFF) idle_secs++;
        if (idle_secs >= idle_limit) push_stamp(IDLE_MARK, valve);
        if (pending) begin
          pending = 0;
          rep.decided = estimate_flow(valve, flow, shut);
          rep.flow = flow;
          rep.shut = shut;
        end
      end
      rep.high = flag;
      expected_reports.push_back(rep);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_report(guard_report_t got);
      guard_report_t want;
      if (expected_reports.size() == 0) begin
        $error("result with no item waiting: flow_estimate %0d", got.flow);
        mismatches++;
        return;
      end
      want = expected_reports.pop_front();
      compare_field("flow_estimate", want.flow, got.flow);
      compare_field("decided", want.decided, got.decided);
      compare_field("high_flow", want.high, got.high);
      compare_field("shutoff_request", want.shut, got.shut);
    endfunction

    function int outstanding();
      return expected_reports.size();
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  logic                 in_valid;
  logic                 in_ready;
  logic                 in_command;
  logic [STAMP_W-1:0]   in_pulse_time;
  logic                 in_valve_open;
  logic                 out_valid;
  logic                 out_ready;
  logic [FLOW_W-1:0]    out_flow_estimate;
  logic                 out_decided;
  logic                 out_high_flow;
  logic                 out_shutoff_request;

  flow_guard_tracker tracker;
  bit steady;
  int hold_req;

  pulse_rate_high_flow_guard DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_command          (in_command),
    .in_pulse_time       (in_pulse_time),
    .in_valve_open       (in_valve_open),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_flow_estimate   (out_flow_estimate),
    .out_decided         (out_decided),
    .out_high_flow       (out_high_flow),
    .out_shutoff_request (out_shutoff_request)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Mostly short gaps, a few long ones
  function automatic int gap_len();
    if ($urandom_range(99, 0) < 90) return $urandom_range(3, 1);
    return $urandom_range(60, 15);
  endfunction

  // Offer one item and hold it until the guard takes it
  task automatic send_item(logic cmd, logic [STAMP_W-1:0] stamp, logic valve);
    int gap;
    gap = (steady || $urandom_range(99, 0) < 65) ? 0 : gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_command    <= cmd;
    in_pulse_time <= stamp;
    in_valve_open <= valve;
    do @(posedge clk); while (!in_ready);
    tracker.accept_item(cmd, stamp, valve);
  endtask

  // Stop offering and drain every outstanding report
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (tracker.outstanding() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    tracker.write_reg(idx, data);
  endtask

  task automatic set_config(bit en, logic [CFG_W-1:0] scale, logic [CFG_W-1:0] maxf,
                            logic [CFG_W-1:0] idle);
    wait_idle();
    // Upper bits of the enable write are don't-care; toggle them anyway
    write_reg(REG_GUARD_ENABLE, CFG_W'(($urandom & 16'hFFFE) | en));
    write_reg(REG_METER_SCALE, scale);
    write_reg(REG_MAX_FLOW, maxf);
    write_reg(REG_IDLE_PUSH, idle);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly well-formed pulse trains with ticks between, the rest noise
  task automatic run_random(int count, int hold_at, int pause_at);
    int sent;
    int step_max;
    int r;
    logic [STAMP_W-1:0] stamp;
    sent = 0;
    while (sent < count) begin
      if (hold_at >= 0 && sent >= hold_at) begin
        hold_req = HOLD_CYCLES;
        hold_at = -1;
      end
      if (pause_at >= 0 && sent >= pause_at) begin
        wait_idle();
        pause_at = -1;
      end
      if ($urandom_range(99, 0) < 80) begin
        stamp = $urandom;
        case ($urandom_range(5, 0))
          0: step_max = 0;
          1: step_max = 1;
          2: step_max = 8;
          3: step_max = 40;
          4: step_max = 300;
          default: step_max = 20000;
        endcase
        repeat ($urandom_range(45, 21)) begin
          r = $urandom_range(99, 0);
          if (r < 4) begin
            send_item(CMD_PULSE, stamp - $urandom_range(5000, 1), 1'b1);
          end else begin
            stamp = stamp + $urandom_range(step_max, 0);
            send_item(CMD_PULSE, stamp, r >= 7);
          end
          sent++;
          if ($urandom_range(99, 0) < 45) begin
            send_item(CMD_TICK, $urandom, $urandom_range(99, 0) >= 5);
            sent++;
          end
        end
      end else begin
        repeat ($urandom_range(8, 1)) begin
          send_item(1'($urandom_range(1, 0)), $urandom, 1'($urandom_range(1, 0)));
          sent++;
        end
      end
    end
  endtask

  task automatic run_phase(bit en, logic [CFG_W-1:0] scale, logic [CFG_W-1:0] maxf,
                           logic [CFG_W-1:0] idle, int count, bit calm,
                           int hold_at, int pause_at);
    set_config(en, scale, maxf, idle);
    steady = calm;
    run_random(count, hold_at, pause_at);
  endtask

  // Receive reports, check them, and stall at random or on request
  initial begin
    int stall_left;
    stall_left = 0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready)
        tracker.check_report({out_flow_estimate, out_decided, out_high_flow,
                              out_shutoff_request});
      if (stall_left == 0 && hold_req != 0) begin
        stall_left = hold_req;
        hold_req = 0;
      end else if (stall_left == 0 && !steady && $urandom_range(99, 0) < 25) begin
        stall_left = gap_len();
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Main sequence
  initial begin
    tracker       = new();
    steady        = 0;
    hold_req      = 0;
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    in_valid      = 1'b0;
    in_command    = CMD_PULSE;
    in_pulse_time = '0;
    in_valve_open = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    repeat (4) @(posedge clk);

    // Directed: closed valve, markers in window, zero span, dropped check, bad order
    set_config(1'b1, 16'd100, 16'd480, 16'd60);
    send_item(CMD_TICK, $urandom, 1'b1);
    send_item(CMD_PULSE, 32'h0000_0000, 1'b0);
    send_item(CMD_PULSE, 32'hFFFF_FFFF, 1'b0);
    send_item(CMD_PULSE, 32'd1000, 1'b1);
    send_item(CMD_TICK, $urandom, 1'b1);
    repeat (20) send_item(CMD_PULSE, 32'd1000, 1'b1);
    send_item(CMD_TICK, $urandom, 1'b1);
    send_item(CMD_PULSE, 32'hFFFF_FFFE, 1'b1);
    send_item(CMD_TICK, $urandom, 1'b0);
    send_item(CMD_PULSE, 32'd5, 1'b1);
    send_item(CMD_TICK, $urandom, 1'b1);

    // Random phases over several register settings
    run_phase(1'b1, 16'd100, 16'd480, 16'd60, 250, 1'b0, 60, 150);
    run_phase(1'b0, 16'd100, 16'd480, 16'd60, 100, 1'b0, -1, -1);
    run_phase(1'b1, 16'd1, 16'd65535, 16'd65535, 200, 1'b1, -1, -1);
    run_phase(1'b1, 16'd65535, 16'd0, 16'd40, 150, 1'b0, -1, -1);
    run_phase(1'b1, 16'd0, 16'd1000, 16'd0, 60, 1'b0, -1, -1);
    run_phase(1'b1, 16'd37, 16'd2000, 16'd1, 60, 1'b0, -1, -1);
    run_phase(1'b1, 16'd0, 16'd65535, 16'd30, 150, 1'b0, -1, -1);
    run_phase(1'b1, CFG_W'($urandom_range(400, 1)), CFG_W'($urandom_range(5000, 100)),
              CFG_W'($urandom_range(100, 5)), 150, 1'b0, -1, -1);
    run_phase(1'b1, 16'd250, 16'd200, 16'd3, 130, 1'b0, -1, -1);

    // Drain, then allow stray reports to show up
    wait_idle();
    repeat (60) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.outstanding() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Bound the run
  initial begin
    #12_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/prhfg_pkg.sv
hw/rtl/prhfg_div.sv
hw/rtl/prhfg_datapath.sv
hw/rtl/prhfg_ctrl.sv
hw/rtl/pulse_rate_high_flow_guard.sv
tb/tb.sv
